// ===== src/dsq_pkg.sv =====
package dsq_pkg;

  localparam int FRAC_DIGITS  = 8;
  localparam int INT_DIGITS   = 9;
  localparam int TOTAL_DIGITS = INT_DIGITS + FRAC_DIGITS;

  localparam int RAD_W  = 128;
  localparam int ROOT_W = 64;
  localparam int REM_W  = ROOT_W + 2;
  localparam int OUT_W  = 57;
  localparam int CNT_W  = 6;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  function automatic logic [RAD_W-1:0] pow10(input int n);
    logic [RAD_W-1:0] r;
    r = RAD_W'(1);
    for (int i = 0; i < n; i++) begin
      r = r * RAD_W'(10);
    end
    return r;
  endfunction

  localparam logic [RAD_W-1:0] ROOT_LIMIT = pow10(TOTAL_DIGITS);
  localparam logic [RAD_W-1:0] RAD_LIMIT  = pow10(2 * TOTAL_DIGITS);
  localparam logic [OUT_W-1:0] ROOT_MAX   = OUT_W'(ROOT_LIMIT - RAD_W'(1));

endpackage

// ===== src/decimal_digit_square_root_core.sv =====
// Square root of a 128-bit radicand (value times 10^16, split over two words),
// returned truncated and times 10^8. Pulse start while busy is low; busy then
// stays high while one compare-subtract unit over a 66-bit remainder
// resolves one root bit per cycle over all 64 root bits, followed by one
// cycle with done high. The result is valid only in the cycle done is high
// and must be captured then: the receiver cannot stall the block. Roots that
// do not fit in 17 decimal digits give the all-nines value and saturated set.
// A new radicand is taken only when busy is low, not during a computation.
module decimal_digit_square_root_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [63:0]                 radicand_upper,
  input  logic [63:0]                 radicand_lower,
  output logic                        done,
  output logic [dsq_pkg::OUT_W-1:0]   root_scaled,
  output logic                        saturated
);

  dsq_pkg::state_t               state, state_next;
  logic [dsq_pkg::RAD_W-1:0]     rad;
  logic [dsq_pkg::REM_W-1:0]     rem;
  logic [dsq_pkg::ROOT_W-1:0]    root;
  logic [dsq_pkg::CNT_W-1:0]     count;
  logic                          sat;

  logic [dsq_pkg::REM_W-1:0]     rem_sh;
  logic [dsq_pkg::REM_W-1:0]     trial;
  logic                          fits;
  logic                          accept;

  assign accept = start && !busy;
  assign busy   = (state != dsq_pkg::ST_IDLE);
  assign done   = (state == dsq_pkg::ST_FINISH);

  // shared compare-subtract unit
  assign rem_sh = {rem[dsq_pkg::REM_W-3:0], rad[dsq_pkg::RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  assign root_scaled = sat ? dsq_pkg::ROOT_MAX : root[dsq_pkg::OUT_W-1:0];
  assign saturated   = sat;

  always_comb begin
    state_next = state;
    unique case (state)
      dsq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = dsq_pkg::ST_CALC;
        end
      end
      dsq_pkg::ST_CALC: begin
        if (count == '1) begin
          state_next = dsq_pkg::ST_FINISH;
        end
      end
      dsq_pkg::ST_FINISH: begin
        state_next = dsq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= '0;
      end else if (state == dsq_pkg::ST_CALC) begin
        count <= count + dsq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rad  <= {radicand_upper, radicand_lower};
      sat  <= ({radicand_upper, radicand_lower} >= dsq_pkg::RAD_LIMIT);
      rem  <= '0;
      root <= '0;
    end else if (state == dsq_pkg::ST_CALC) begin
      rad  <= {rad[dsq_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[dsq_pkg::ROOT_W-2:0], fits};
    end
  end

`ifndef ASSERT_OFF
  a_done_after_calc: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == dsq_pkg::ST_CALC) && $past(count) == '1)
    else $error("result without a full iteration run");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && count == '0)
    else $error("accepted item did not start the iteration");

  a_fit_when_unsat: assert property (@(posedge clk) disable iff (rst)
    (done && !saturated) |-> root[dsq_pkg::ROOT_W-1:dsq_pkg::OUT_W] == '0
      && root < dsq_pkg::ROOT_W'(dsq_pkg::ROOT_LIMIT))
    else $error("unsaturated root out of range");
`endif

endmodule
